[src/msp_pkg.sv]
package msp_pkg;

   localparam logic [2:0] MARK_LEN  = 3'd6;
   localparam logic [2:0] MARK_LAST = 3'd5;

   localparam logic [7:0] BYTE_ESC   = 8'd27;
   localparam logic [7:0] BYTE_CR    = 8'd13;
   localparam logic [7:0] BYTE_LF    = 8'd10;
   localparam logic [7:0] BYTE_HASH  = 8'd35;
   localparam logic [7:0] DIGIT_LOW  = 8'd48;
   localparam logic [7:0] DIGIT_HIGH = 8'd58;

   localparam logic [1:0] KIND_STORE = 2'd0;
   localparam logic [1:0] KIND_BEGIN = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_EXIT  = 2'd3;

   typedef enum logic [2:0] {
      EVT_NONE,
      EVT_ESC,
      EVT_BEGIN,
      EVT_END,
      EVT_FLUSH
   } evt_type;

   typedef struct packed {
      logic apply;
      logic flush_init;
      logic flush_step;
   } cmd_type;

   typedef struct packed {
      evt_type evt;
      logic    slot_free;
      logic    flush_last;
   } status_type;

   function automatic logic begin_match(input logic [2:0] pos, input logic [7:0] b);
      logic hit;
      if (pos == 3'd2 || pos == 3'd3) begin
         hit = (b >= DIGIT_LOW) && (b <= DIGIT_HIGH);
      end else begin
         hit = (b == BYTE_HASH);
      end
      return hit;
   endfunction

endpackage

[src/msp_if.sv]
interface msp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface msp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  segment_number;
   logic [15:0] write_address;
   logic [7:0]  write_data;
   logic        last_of_run;

   modport source (output valid, output result_kind, output segment_number,
                   output write_address, output write_data, output last_of_run,
                   input ready);
   modport sink (input valid, input result_kind, input segment_number,
                 input write_address, input write_data, input last_of_run,
                 output ready);
endinterface

[src/msp_ctrl.sv]
module msp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  msp_pkg::status_type status,
   output msp_pkg::cmd_type    cmd,
   output logic                req_ready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in        = state_ff;
      cmd.apply       = 1'b0;
      cmd.flush_init  = 1'b0;
      cmd.flush_step  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.evt == msp_pkg::EVT_FLUSH) begin
               cmd.flush_init = 1'b1;
               state_in       = ST_FLUSH;
            end else if (status.evt == msp_pkg::EVT_NONE || status.slot_free) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.slot_free) begin
               cmd.flush_step = 1'b1;
               if (status.flush_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

[src/msp_datapath.sv]
module msp_datapath #(
   parameter int ADDR_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic [7:0]           rx_byte,
   input  msp_pkg::cmd_type     cmd,
   output msp_pkg::status_type  status,
   msp_rsp_if.source            rsp
);

   logic [7:0]            byte_ff, byte_in;
   logic                  mode_ff, mode_in;
   logic [2:0]            count_ff, count_in;
   logic                  blive_ff, blive_in;
   logic                  elive_ff, elive_in;
   logic [7:0]            held_ff [0:5];
   logic [7:0]            held_in [0:5];
   logic [7:0]            seg_ff, seg_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [2:0]            idx_ff, idx_in;
   logic                  lf_ff, lf_in;

   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_kind_ff, out_kind_in;
   logic [7:0]            out_seg_ff, out_seg_in;
   logic [15:0]           out_addr_ff, out_addr_in;
   logic [7:0]            out_data_ff, out_data_in;
   logic                  out_last_ff, out_last_in;

   logic [2:0]            kval;
   logic                  bm;
   logic                  nb;
   logic                  ne;
   logic                  is_hash;
   logic                  slot_free;
   msp_pkg::evt_type      evt;
   logic [7:0]            flush_byte;
   logic                  flush_last;
   logic [31:0]           addr_wide;
   logic [ADDR_WIDTH-1:0] addr_next;

   assign kval      = (count_ff >= msp_pkg::MARK_LEN) ? 3'd0 : count_ff;
   assign bm        = msp_pkg::begin_match(kval, byte_ff);
   assign is_hash   = (byte_ff == msp_pkg::BYTE_HASH);
   assign nb        = blive_ff && bm;
   assign ne        = elive_ff && is_hash;
   assign slot_free = !out_valid_ff || rsp.ready;
   assign addr_wide = 32'(addr_ff);
   assign addr_next = addr_ff + ADDR_WIDTH'(1);

   always_comb begin
      if (byte_ff == msp_pkg::BYTE_ESC) begin
         evt = msp_pkg::EVT_ESC;
      end else if (!mode_ff) begin
         evt = (bm && kval == msp_pkg::MARK_LAST) ? msp_pkg::EVT_BEGIN : msp_pkg::EVT_NONE;
      end else if (ne && kval == msp_pkg::MARK_LAST) begin
         evt = msp_pkg::EVT_END;
      end else if (nb && kval == msp_pkg::MARK_LAST) begin
         evt = msp_pkg::EVT_BEGIN;
      end else if (nb || ne) begin
         evt = msp_pkg::EVT_NONE;
      end else begin
         evt = msp_pkg::EVT_FLUSH;
      end
   end

   assign flush_byte = (idx_ff < kval) ? held_ff[idx_ff] : byte_ff;
   assign flush_last = (idx_ff == kval) && (lf_ff || flush_byte != msp_pkg::BYTE_CR);

   assign status.evt        = evt;
   assign status.slot_free  = slot_free;
   assign status.flush_last = flush_last;

   always_comb begin
      byte_in      = byte_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      blive_in     = blive_ff;
      elive_in     = elive_ff;
      held_in      = held_ff;
      seg_in       = seg_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      lf_in        = lf_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_kind_in  = out_kind_ff;
      out_seg_in   = out_seg_ff;
      out_addr_in  = out_addr_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;

      if (req_fire) begin
         byte_in = rx_byte;
      end

      if (cmd.apply) begin
         if (evt != msp_pkg::EVT_NONE) begin
            out_seg_in  = seg_ff;
            out_addr_in = 16'd0;
            out_data_in = 8'd0;
            out_last_in = 1'b1;
         end
         case (evt)
            msp_pkg::EVT_ESC: begin
               out_valid_in = 1'b1;
               out_kind_in  = msp_pkg::KIND_EXIT;
            end
            msp_pkg::EVT_BEGIN: begin
               out_valid_in = 1'b1;
               out_kind_in  = msp_pkg::KIND_BEGIN;
               mode_in      = 1'b1;
               count_in     = 3'd0;
               blive_in     = 1'b1;
               elive_in     = 1'b1;
            end
            msp_pkg::EVT_END: begin
               out_valid_in = 1'b1;
               out_kind_in  = msp_pkg::KIND_END;
               mode_in      = 1'b0;
               count_in     = 3'd0;
               blive_in     = 1'b1;
               elive_in     = 1'b1;
               seg_in       = seg_ff + 8'd1;
               addr_in      = '0;
            end
            msp_pkg::EVT_NONE: begin
               if (!mode_ff) begin
                  if (bm) begin
                     count_in = kval + 3'd1;
                  end else if (is_hash) begin
                     count_in = (kval == 3'd2) ? 3'd2 : 3'd1;
                  end else begin
                     count_in = 3'd0;
                  end
               end else begin
                  held_in[kval] = byte_ff;
                  count_in      = kval + 3'd1;
                  blive_in      = nb;
                  elive_in      = ne;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.flush_init) begin
         idx_in = 3'd0;
         lf_in  = 1'b0;
      end

      if (cmd.flush_step) begin
         out_valid_in = 1'b1;
         out_kind_in  = msp_pkg::KIND_STORE;
         out_seg_in   = seg_ff;
         out_addr_in  = addr_wide[15:0];
         out_last_in  = flush_last;
         addr_in      = addr_next;
         if (lf_ff) begin
            out_data_in = msp_pkg::BYTE_LF;
            lf_in       = 1'b0;
            idx_in      = idx_ff + 3'd1;
         end else begin
            out_data_in = flush_byte;
            if (flush_byte == msp_pkg::BYTE_CR) begin
               lf_in = 1'b1;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         if (flush_last) begin
            count_in = 3'd0;
            blive_in = 1'b1;
            elive_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         count_ff     <= 3'd0;
         blive_ff     <= 1'b1;
         elive_ff     <= 1'b1;
         seg_ff       <= 8'd0;
         addr_ff      <= '0;
         idx_ff       <= 3'd0;
         lf_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         blive_ff     <= blive_in;
         elive_ff     <= elive_in;
         seg_ff       <= seg_in;
         addr_ff      <= addr_in;
         idx_ff       <= idx_in;
         lf_ff        <= lf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      held_ff     <= held_in;
      out_kind_ff <= out_kind_in;
      out_seg_ff  <= out_seg_in;
      out_addr_ff <= out_addr_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.result_kind    = out_kind_ff;
   assign rsp.segment_number = out_seg_ff;
   assign rsp.write_address  = out_addr_ff;
   assign rsp.write_data     = out_data_ff;
   assign rsp.last_of_run    = out_last_ff;

endmodule

[src/marker_delimited_segment_parser_top.sv]
// Parses a received byte stream into numbered segments framed by text markers.
// The req channel takes one received byte per beat. The rsp channel gives result
// beats: stores with segment, address and data, segment begin, segment end and
// exit on ESC; the last beat caused by a byte carries last_of_run.
// A byte is taken in a cycle in which the parser is ready, and evaluated in the next
// cycle. A new byte is taken only once the previous one has been evaluated or flushed.
// A segment byte that does not extend a marker flushes the held prefix bytes and
// itself, one store beat per cycle while the output slot is free, with an added LF
// after each CR, up to 7 beats. A single result beat is written to the output
// register in the evaluate step; the store beats of a flush are written in the flush
// step that follows it.
// A single output register lets the next byte be taken while a result waits.
// When the receiver stalls, the pending beat holds and the parser waits in its
// evaluate or flush step, so req_bus.ready stays low until that byte is done.
// Reset clears to pause mode with segment 0 and address 0, no result pending.
module marker_delimited_segment_parser_top #(
   parameter int ADDR_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   msp_req_if.sink   req_bus,
   msp_rsp_if.source rsp_bus
);

   msp_pkg::cmd_type    cmd;
   msp_pkg::status_type status;
   logic                req_ready;
   logic                req_fire;

   assign req_bus.ready = req_ready;
   assign req_fire      = req_bus.valid && req_ready;

   msp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   msp_datapath #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .rx_byte  (req_bus.rx_byte),
      .cmd      (cmd),
      .status   (status),
      .rsp      (rsp_bus)
   );

endmodule

[bench/marker_delimited_segment_parser_top_tb.sv]
module marker_delimited_segment_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PH_FREE       = 0;
   localparam int unsigned PH_SEND_IDLE  = 1;
   localparam int unsigned PH_RECV_STALL = 2;
   localparam int unsigned PH_BOTH       = 3;
   localparam int unsigned PHASE_COUNT   = 4;

   localparam int unsigned BYTE_TARGET = 320;
   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned DRAIN_WAIT  = 40;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  segment;
      logic [15:0] address;
      logic [7:0]  data;
      logic        last;
   } parse_result_type;

   typedef struct {
      logic [7:0]  data;
      int unsigned phase;
   } rx_beat_type;

   logic clock = 1'b0;
   logic reset;

   msp_req_if req_bus ();
   msp_rsp_if rsp_bus ();

   marker_delimited_segment_parser_top #(
      .ADDR_WIDTH(16)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #1 clock = ~clock;

   rx_beat_type      pending_bytes[$];
   parse_result_type expected_results[$];
   logic [7:0]       stim_bytes[$];
   int unsigned      active_phase = PH_FREE;
   int unsigned      fail_count = 0;
   int unsigned      quiet_cycles = 0;

   // Parser state as the checker sees it.
   logic        in_segment;
   logic [2:0]  match_len;
   logic        begin_alive;
   logic        end_alive;
   logic [7:0]  held_chars[0:5];
   logic [7:0]  seg_count;
   logic [15:0] addr_count;

   function automatic logic marker_char_ok(input logic [2:0] pos, input logic [7:0] b);
      if (pos == 3'd2 || pos == 3'd3) begin
         return b >= msp_pkg::DIGIT_LOW && b <= msp_pkg::DIGIT_HIGH;
      end
      return b == msp_pkg::BYTE_HASH;
   endfunction

   function automatic parse_result_type make_result(input logic [1:0] kind,
                                                    input logic [15:0] addr,
                                                    input logic [7:0] data);
      parse_result_type r;
      r.kind    = kind;
      r.segment = seg_count;
      r.address = addr;
      r.data    = data;
      r.last    = 1'b0;
      return r;
   endfunction

   task automatic clear_marker_match();
      match_len   = 3'd0;
      begin_alive = 1'b1;
      end_alive   = 1'b1;
   endtask

   task automatic parse_byte(input logic [7:0] b);
      logic [2:0]       k;
      logic             nb;
      logic             ne;
      logic [7:0]       d;
      parse_result_type run[$];
      k = (match_len >= msp_pkg::MARK_LEN) ? 3'd0 : match_len;
      if (b == msp_pkg::BYTE_ESC) begin
         run.push_back(make_result(msp_pkg::KIND_EXIT, 16'd0, 8'd0));
      end else if (!in_segment) begin
         if (marker_char_ok(k, b)) begin
            if (k == msp_pkg::MARK_LAST) begin
               in_segment = 1'b1;
               clear_marker_match();
               run.push_back(make_result(msp_pkg::KIND_BEGIN, 16'd0, 8'd0));
            end else begin
               match_len = k + 3'd1;
            end
         end else if (b == msp_pkg::BYTE_HASH) begin
            match_len = (k == 3'd2) ? 3'd2 : 3'd1;
         end else begin
            match_len = 3'd0;
         end
      end else begin
         nb = begin_alive && marker_char_ok(k, b);
         ne = end_alive && b == msp_pkg::BYTE_HASH;
         if (ne && k == msp_pkg::MARK_LAST) begin
            run.push_back(make_result(msp_pkg::KIND_END, 16'd0, 8'd0));
            in_segment = 1'b0;
            clear_marker_match();
            seg_count  = seg_count + 8'd1;
            addr_count = 16'd0;
         end else if (nb && k == msp_pkg::MARK_LAST) begin
            clear_marker_match();
            run.push_back(make_result(msp_pkg::KIND_BEGIN, 16'd0, 8'd0));
         end else if (nb || ne) begin
            held_chars[k] = b;
            match_len     = k + 3'd1;
            begin_alive   = nb;
            end_alive     = ne;
         end else begin
            for (int i = 0; i <= int'(k); i++) begin
               d = (i < int'(k)) ? held_chars[i] : b;
               run.push_back(make_result(msp_pkg::KIND_STORE, addr_count, d));
               addr_count = addr_count + 16'd1;
               if (d == msp_pkg::BYTE_CR) begin
                  run.push_back(make_result(msp_pkg::KIND_STORE, addr_count,
                                            msp_pkg::BYTE_LF));
                  addr_count = addr_count + 16'd1;
               end
            end
            clear_marker_match();
         end
      end
      if (run.size() > 0) begin
         run[run.size() - 1].last = 1'b1;
      end
      foreach (run[i]) begin
         expected_results.push_back(run[i]);
      end
   endtask

   task automatic check_result();
      parse_result_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result beat: kind %0d data %0d", rsp_bus.result_kind,
                rsp_bus.write_data);
         fail_count++;
         return;
      end
      want = expected_results.pop_front();
      if (rsp_bus.result_kind !== want.kind) begin
         $error("result_kind: expected %0d, got %0d", want.kind, rsp_bus.result_kind);
         fail_count++;
      end
      if (rsp_bus.segment_number !== want.segment) begin
         $error("segment_number: expected %0d, got %0d", want.segment,
                rsp_bus.segment_number);
         fail_count++;
      end
      if (rsp_bus.write_address !== want.address) begin
         $error("write_address: expected %0d, got %0d", want.address,
                rsp_bus.write_address);
         fail_count++;
      end
      if (rsp_bus.write_data !== want.data) begin
         $error("write_data: expected %0d, got %0d", want.data, rsp_bus.write_data);
         fail_count++;
      end
      if (rsp_bus.last_of_run !== want.last) begin
         $error("last_of_run: expected %0d, got %0d", want.last, rsp_bus.last_of_run);
         fail_count++;
      end
   endtask

   function automatic bit sender_rests(input int unsigned phase);
      case (phase)
         PH_SEND_IDLE: return $urandom_range(99) < 86;
         PH_BOTH:      return $urandom_range(99) < 7;
         default:      return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls(input int unsigned phase);
      case (phase)
         PH_RECV_STALL: return $urandom_range(99) < 86;
         PH_BOTH:       return $urandom_range(99) < 7;
         default:       return 1'b0;
      endcase
   endfunction

   // A new beat is offered only once the previous one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= 8'd0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            parse_byte(req_bus.rx_byte);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_bytes.size() > 0 && !sender_rests(pending_bytes[0].phase)) begin
               req_bus.valid   <= 1'b1;
               req_bus.rx_byte <= pending_bytes[0].data;
               active_phase    <= pending_bytes[0].phase;
               pending_bytes.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_result();
         end
         rsp_bus.ready <= !receiver_stalls(active_phase);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         stim_bytes.push_back(s[i]);
      end
   endtask

   function automatic logic [7:0] random_digit();
      return 8'($urandom_range(msp_pkg::DIGIT_HIGH, msp_pkg::DIGIT_LOW));
   endfunction

   task automatic add_begin_marker();
      add_text("##");
      stim_bytes.push_back(random_digit());
      stim_bytes.push_back(random_digit());
      add_text("##");
   endtask

   task automatic add_content_byte();
      case ($urandom_range(11)) inside
         [0:3]:      stim_bytes.push_back(8'($urandom_range(255)));
         4:          stim_bytes.push_back(msp_pkg::BYTE_HASH);
         5:          stim_bytes.push_back(random_digit());
         6:          stim_bytes.push_back(msp_pkg::BYTE_CR);
         7:          stim_bytes.push_back(msp_pkg::BYTE_ESC);
         8: begin
            repeat ($urandom_range(5, 1)) stim_bytes.push_back(msp_pkg::BYTE_HASH);
            stim_bytes.push_back(8'($urandom_range(255)));
         end
         9: begin
            add_text("##");
            stim_bytes.push_back(random_digit());
            stim_bytes.push_back(8'($urandom_range(255)));
         end
         10:      add_begin_marker();
         default: stim_bytes.push_back(8'($urandom_range(255, 128)));
      endcase
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'd0;
      rsp_bus.ready   = 1'b0;
      reset           = 1'b1;

      in_segment = 1'b0;
      clear_marker_match();
      foreach (held_chars[i]) held_chars[i] = 8'd0;
      seg_count  = 8'd0;
      addr_count = 16'd0;

      // Pause mode: ESC, then a partial marker that breaks after a digit and restarts.
      stim_bytes.push_back(msp_pkg::BYTE_ESC);
      add_text("##5##0:##");
      // Segment contents: top byte value, CR with its LF, ESC, a flush ending in '#'.
      stim_bytes.push_back(8'hFF);
      stim_bytes.push_back(msp_pkg::BYTE_CR);
      stim_bytes.push_back(msp_pkg::BYTE_ESC);
      add_text("##9#");
      // A begin marker inside a segment, then the end marker.
      add_text("##:0##");
      add_text("######");

      while (stim_bytes.size() < BYTE_TARGET) begin
         if ($urandom_range(99) < 75) begin
            add_begin_marker();
            repeat ($urandom_range(12, 1)) add_content_byte();
            if ($urandom_range(4) == 0) begin
               add_text("###");
               stim_bytes.push_back(8'($urandom_range(255)));
            end
            add_text("######");
         end else begin
            repeat ($urandom_range(8, 1)) add_content_byte();
         end
      end

      foreach (stim_bytes[i]) begin
         pending_bytes.push_back('{data: stim_bytes[i],
                                   phase: (i * PHASE_COUNT) / stim_bytes.size()});
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() > 0 || req_bus.valid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
src/msp_pkg.sv
src/msp_if.sv
src/msp_ctrl.sv
src/msp_datapath.sv
src/marker_delimited_segment_parser_top.sv
bench/marker_delimited_segment_parser_top_tb.sv
